FILE: rtl/opam_pkg.sv
// Package for the oscillation period and amplitude meter.
// Holds the sequencer state type and the fixed count width.
// No dependencies.
`default_nettype none

package opam_pkg;

    // extremum_count and period_count width
    localparam int CNT_BITS = 32;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_STEP  = 9'b000000010,
        ST_DIFF  = 9'b000000100,
        ST_STATS = 9'b000001000,
        ST_LOADP = 9'b000010000,
        ST_WAITP = 9'b000100000,
        ST_LOADS = 9'b001000000,
        ST_WAITS = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/opam_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the top level for the two averages.
`default_nettype none

module opam_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic [NUM_BITS-1:0]      quot
);

    localparam int CW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS-1:0] rem_reg;

    logic [DEN_BITS:0]   rem_sh;
    logic                ge;
    logic [DEN_BITS:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[NUM_BITS-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/oscillation_period_amplitude_meter.sv
// Top level of the oscillation period and amplitude meter.
// Depends on opam_pkg (state type, count width) and opam_div (serial divider).
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_stall  | sample_time, sample_value, end_of_group
//  output  | out_valid/out_stall| accepted, stats_valid, value_*, period_*, amplitude_*
//
// One transaction at a time: in_stall is high from acceptance until the result
// is loaded into the output register. A sample that marks no extremum passes
// through accept, step and load. A sample that marks an extremum adds a
// difference step, a period/swing update and a divider load; once a period
// exists, two runs of the serial divider follow, with one more load step
// between them.
// Reset is asynchronous, active low, and needs no clearing pass. A stalled
// result holds in the output register; the next sample is taken meanwhile and
// waits in the load step until the register is free.
`default_nettype none

module oscillation_period_amplitude_meter #(
    parameter int TIME_BITS  = 32,
    parameter int VALUE_BITS = 24,
    parameter int SUM_BITS   = 48
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [TIME_BITS-1:0]  sample_time,
    input  wire logic signed [VALUE_BITS-1:0] sample_value,
    input  wire logic                         end_of_group,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              accepted,
    output logic                              stats_valid,
    output logic signed [VALUE_BITS-1:0]      value_max,
    output logic signed [VALUE_BITS-1:0]      value_min,
    output logic [TIME_BITS-1:0]              period_max,
    output logic [TIME_BITS-1:0]              period_min,
    output logic [TIME_BITS-1:0]              period_avg,
    output logic [VALUE_BITS-1:0]             amplitude_max,
    output logic [VALUE_BITS-1:0]             amplitude_min,
    output logic [VALUE_BITS-1:0]             amplitude_avg
);

    localparam int CB    = opam_pkg::CNT_BITS;
    // wide enough for either saturating sum plus carry
    localparam int ADD_W = ((TIME_BITS > SUM_BITS) ? TIME_BITS : SUM_BITS) + 1;
    localparam logic [CB-1:0]       CNT_MAX = {CB{1'b1}};
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    opam_pkg::state_t state_reg, state_next;

    // captured transaction
    logic signed [TIME_BITS-1:0]  t_reg;
    logic signed [VALUE_BITS-1:0] v_reg;
    logic                         last_reg;
    logic                         acc_reg;

    // analysis state
    logic                         have_sample_reg;
    logic signed [TIME_BITS-1:0]  last_time_reg;
    logic signed [VALUE_BITS-1:0] prev_value_reg;
    logic                         rising_reg;
    logic                         falling_reg;
    logic                         skip_rest_reg;
    logic signed [VALUE_BITS-1:0] run_max_reg;
    logic signed [VALUE_BITS-1:0] run_min_reg;
    logic [CB-1:0]                ext_count_reg;
    logic [TIME_BITS-1:0]         period_start_reg;
    logic signed [VALUE_BITS-1:0] last_ext_reg;
    logic [TIME_BITS-1:0]         longest_reg;
    logic [TIME_BITS-1:0]         shortest_reg;
    logic [SUM_BITS-1:0]          period_sum_reg;
    logic [CB-1:0]                period_count_reg;
    logic [VALUE_BITS-1:0]        largest_reg;
    logic [VALUE_BITS-1:0]        smallest_reg;
    logic [SUM_BITS-1:0]          swing_sum_reg;
    logic [TIME_BITS-1:0]         period_avg_reg;
    logic [VALUE_BITS-1:0]        swing_avg_reg;

    // extremum step scratch
    logic [TIME_BITS-1:0]         p_reg;
    logic [VALUE_BITS-1:0]        swing_reg;

    // output register
    logic                         out_valid_reg;
    logic                         o_acc_reg;
    logic                         o_stats_reg;
    logic signed [VALUE_BITS-1:0] o_vmax_reg;
    logic signed [VALUE_BITS-1:0] o_vmin_reg;
    logic [TIME_BITS-1:0]         o_pmax_reg;
    logic [TIME_BITS-1:0]         o_pmin_reg;
    logic [TIME_BITS-1:0]         o_pavg_reg;
    logic [VALUE_BITS-1:0]        o_amax_reg;
    logic [VALUE_BITS-1:0]        o_amin_reg;
    logic [VALUE_BITS-1:0]        o_aavg_reg;

    // step decisions
    logic                         acc;
    logic signed [VALUE_BITS-1:0] eff_prev;
    logic signed [VALUE_BITS-1:0] eff_max;
    logic signed [VALUE_BITS-1:0] eff_min;
    logic                         up;
    logic                         down;
    logic                         is_ext;

    // extremum arithmetic
    logic signed [VALUE_BITS:0]   diff_wide;
    logic [VALUE_BITS:0]          abs_wide;
    logic [ADD_W-1:0]             psum_wide;
    logic [ADD_W-1:0]             ssum_wide;
    logic [CB-1:0]                swing_den;

    // divider
    logic                         div_start;
    logic [SUM_BITS-1:0]          div_num;
    logic [CB-1:0]                div_den;
    logic                         div_done;
    logic [SUM_BITS-1:0]          div_quot;

    logic                         out_free;

    assign acc      = !skip_rest_reg && (!have_sample_reg || (t_reg > last_time_reg));
    assign eff_prev = have_sample_reg ? prev_value_reg : v_reg;
    assign eff_max  = (have_sample_reg && run_max_reg > v_reg) ? run_max_reg : v_reg;
    assign eff_min  = (have_sample_reg && run_min_reg < v_reg) ? run_min_reg : v_reg;
    assign up       = v_reg > eff_prev;
    assign down     = v_reg < eff_prev;
    assign is_ext   = ((up && falling_reg) || (down && rising_reg)) && (ext_count_reg != CNT_MAX);

    assign diff_wide = {v_reg[VALUE_BITS-1], v_reg} - {last_ext_reg[VALUE_BITS-1], last_ext_reg};
    assign abs_wide  = diff_wide[VALUE_BITS] ? -diff_wide : diff_wide;

    assign psum_wide = ADD_W'(period_sum_reg) + ADD_W'(p_reg);
    assign ssum_wide = ADD_W'(swing_sum_reg) + ADD_W'(swing_reg);
    assign swing_den = ext_count_reg - 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;

    // divider hookup: period average first, then swing average
    assign div_start = (state_reg == opam_pkg::ST_LOADP && period_count_reg != '0)
                    || (state_reg == opam_pkg::ST_LOADS && swing_den != '0);
    assign div_num   = (state_reg == opam_pkg::ST_LOADP) ? period_sum_reg : swing_sum_reg;
    assign div_den   = (state_reg == opam_pkg::ST_LOADP) ? period_count_reg : swing_den;

    opam_div #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (CB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            opam_pkg::ST_IDLE:
                if (in_valid) state_next = opam_pkg::ST_STEP;
            opam_pkg::ST_STEP:
                state_next = (acc && is_ext) ? opam_pkg::ST_DIFF : opam_pkg::ST_DONE;
            opam_pkg::ST_DIFF:
                state_next = opam_pkg::ST_STATS;
            opam_pkg::ST_STATS:
                state_next = opam_pkg::ST_LOADP;
            opam_pkg::ST_LOADP:
                state_next = (period_count_reg != '0) ? opam_pkg::ST_WAITP : opam_pkg::ST_DONE;
            opam_pkg::ST_WAITP:
                if (div_done) state_next = opam_pkg::ST_LOADS;
            opam_pkg::ST_LOADS:
                state_next = (swing_den != '0) ? opam_pkg::ST_WAITS : opam_pkg::ST_DONE;
            opam_pkg::ST_WAITS:
                if (div_done) state_next = opam_pkg::ST_DONE;
            opam_pkg::ST_DONE:
                if (out_free) state_next = opam_pkg::ST_IDLE;
            default:
                state_next = opam_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= opam_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            have_sample_reg  <= 1'b0;
            last_time_reg    <= '0;
            prev_value_reg   <= '0;
            rising_reg       <= 1'b0;
            falling_reg      <= 1'b0;
            skip_rest_reg    <= 1'b0;
            run_max_reg      <= '0;
            run_min_reg      <= '0;
            ext_count_reg    <= '0;
            period_start_reg <= '0;
            last_ext_reg     <= '0;
            longest_reg      <= '0;
            shortest_reg     <= '1;
            period_sum_reg   <= '0;
            period_count_reg <= '0;
            largest_reg      <= '0;
            smallest_reg     <= '1;
            swing_sum_reg    <= '0;
            period_avg_reg   <= '0;
            swing_avg_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                opam_pkg::ST_STEP:
                begin
                    if (acc)
                    begin
                        have_sample_reg <= 1'b1;
                        run_max_reg     <= eff_max;
                        run_min_reg     <= eff_min;
                        rising_reg      <= up;
                        falling_reg     <= down;
                        prev_value_reg  <= v_reg;
                        last_time_reg   <= t_reg;
                    end
                    // end of group always releases the skip
                    if (last_reg)
                        skip_rest_reg <= 1'b0;
                    else if (!acc)
                        skip_rest_reg <= 1'b1;
                end
                opam_pkg::ST_STATS:
                begin
                    if (!ext_count_reg[0])
                    begin
                        if (ext_count_reg != '0)
                        begin
                            if (p_reg > longest_reg)  longest_reg  <= p_reg;
                            if (p_reg < shortest_reg) shortest_reg <= p_reg;
                            period_sum_reg <= (psum_wide > ADD_W'(SUM_MAX)) ?
                                              SUM_MAX : psum_wide[SUM_BITS-1:0];
                            if (period_count_reg != CNT_MAX)
                                period_count_reg <= period_count_reg + 1'b1;
                        end
                        period_start_reg <= t_reg;
                    end
                    if (ext_count_reg != '0)
                    begin
                        if (swing_reg > largest_reg)  largest_reg  <= swing_reg;
                        if (swing_reg < smallest_reg) smallest_reg <= swing_reg;
                        swing_sum_reg <= (ssum_wide > ADD_W'(SUM_MAX)) ?
                                         SUM_MAX : ssum_wide[SUM_BITS-1:0];
                    end
                    last_ext_reg  <= v_reg;
                    ext_count_reg <= ext_count_reg + 1'b1;
                end
                opam_pkg::ST_WAITP:
                    if (div_done) period_avg_reg <= TIME_BITS'(div_quot);
                opam_pkg::ST_LOADS:
                    if (swing_den == '0) swing_avg_reg <= '0;
                opam_pkg::ST_WAITS:
                    if (div_done) swing_avg_reg <= VALUE_BITS'(div_quot);
                opam_pkg::ST_DONE:
                    if (out_free) out_valid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // payload: captured sample, scratch and output register
    always_ff @(posedge clk)
    begin
        if (state_reg == opam_pkg::ST_IDLE && in_valid)
        begin
            t_reg    <= sample_time;
            v_reg    <= sample_value;
            last_reg <= end_of_group;
        end
        if (state_reg == opam_pkg::ST_STEP)
            acc_reg <= acc;
        if (state_reg == opam_pkg::ST_DIFF)
        begin
            p_reg     <= t_reg - period_start_reg;
            swing_reg <= abs_wide[VALUE_BITS-1:0];
        end
        if (state_reg == opam_pkg::ST_DONE && out_free)
        begin
            o_acc_reg   <= acc_reg;
            o_stats_reg <= (period_count_reg != '0);
            o_vmax_reg  <= run_max_reg;
            o_vmin_reg  <= run_min_reg;
            if (period_count_reg != '0)
            begin
                o_pmax_reg <= longest_reg;
                o_pmin_reg <= shortest_reg;
                o_pavg_reg <= period_avg_reg;
                o_amax_reg <= largest_reg;
                o_amin_reg <= smallest_reg;
                o_aavg_reg <= swing_avg_reg;
            end
            else
            begin
                o_pmax_reg <= '0;
                o_pmin_reg <= '0;
                o_pavg_reg <= '0;
                o_amax_reg <= '0;
                o_amin_reg <= '0;
                o_aavg_reg <= '0;
            end
        end
    end

    assign in_stall      = (state_reg != opam_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign accepted      = o_acc_reg;
    assign stats_valid   = o_stats_reg;
    assign value_max     = o_vmax_reg;
    assign value_min     = o_vmin_reg;
    assign period_max    = o_pmax_reg;
    assign period_min    = o_pmin_reg;
    assign period_avg    = o_pavg_reg;
    assign amplitude_max = o_amax_reg;
    assign amplitude_min = o_amin_reg;
    assign amplitude_avg = o_aavg_reg;

endmodule

`default_nettype wire
